FILE: src/gfd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gfd_pkg;

   // default widths of the sample and counter paths
   localparam int SampleWidthDef = 16;
   localparam int CountWidthDef  = 8;

   // fixed register field widths
   localparam int AxisWidth     = 2;
   localparam int ThrWidth      = 15;
   localparam int CfgCountWidth = 8;
   localparam int ZoneWidth     = 2;

   // csr port geometry
   localparam int AddrWidth = 5;
   localparam int DataWidth = 32;
   localparam int IdxWidth  = 3;

   // register indexes
   localparam logic [IdxWidth-1:0] REG_UP_AXIS     = 3'd0;
   localparam logic [IdxWidth-1:0] REG_UP_NEGATE   = 3'd1;
   localparam logic [IdxWidth-1:0] REG_THRESHOLD   = 3'd2;
   localparam logic [IdxWidth-1:0] REG_CONFIRM     = 3'd3;
   localparam logic [IdxWidth-1:0] REG_FLAT_LIMIT  = 3'd4;

   // register reset values
   localparam logic [AxisWidth-1:0]     ResetUpAxis    = 2'd0;
   localparam logic                     ResetUpNegate  = 1'b1;
   localparam logic [ThrWidth-1:0]      ResetThreshold = 15'd5734;
   localparam logic [CfgCountWidth-1:0] ResetConfirm   = 8'd4;
   localparam logic [CfgCountWidth-1:0] ResetFlatLimit = 8'd12;

   // axis codes
   localparam logic [AxisWidth-1:0] AXIS_X = 2'd0;
   localparam logic [AxisWidth-1:0] AXIS_Y = 2'd1;
   localparam logic [AxisWidth-1:0] AXIS_Z = 2'd2;

   // zone codes
   localparam logic [ZoneWidth-1:0] ZONE_UPRIGHT = 2'd0;
   localparam logic [ZoneWidth-1:0] ZONE_UPSIDE  = 2'd1;
   localparam logic [ZoneWidth-1:0] ZONE_DEAD    = 2'd2;
   localparam logic [ZoneWidth-1:0] ZONE_FAILED  = 2'd3;

   typedef struct packed {
      logic [AxisWidth-1:0]     up_axis;
      logic                     up_negate;
      logic [ThrWidth-1:0]      tilt_threshold;
      logic [CfgCountWidth-1:0] confirm_polls;
      logic [CfgCountWidth-1:0] flat_polls_limit;
   } cfg_type;

   typedef struct packed {
      logic                 flipped;
      logic                 changed;
      logic [ZoneWidth-1:0] zone;
   } result_type;

endpackage

`default_nettype wire

FILE: src/gravity_flip_detector.sv
// Orientation detector with debounce for a three-axis accelerometer.
// Input channel req_*: one poll per item, read_ok plus the x, y and z samples.
// Result channel rsp_*: one item per poll with flipped, changed and zone.
// Both channels use a valid/ready handshake; the csr port is APB-style with
// pready tied high and registers at byte addresses 0, 4, 8, 12 and 16.
// An item waits in the input register until the result register is free, is
// evaluated against the orientation state and lands in the result register,
// which drives rsp_valid.
// One item is taken every cycle while the
// receiver keeps rsp_ready high; the orientation state and both counters
// update in the same cycle an item is evaluated, so items may follow back to
// back.
// When rsp_ready is low the result register holds its item; the input register
// takes one more only if empty, then req_ready drops until the result drains.
// Reset is synchronous: both registers empty, orientation normal, counters
// cleared and the csr registers back at their defaults.
`timescale 1ns / 1ps
`default_nettype none

module gravity_flip_detector
   import gfd_pkg::*;
#(
   parameter int SAMPLE_WIDTH = SampleWidthDef,
   parameter int COUNT_WIDTH  = CountWidthDef
) (
   input  wire logic                           clock,
   input  wire logic                           reset,

   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic                           req_read_ok,
   input  wire logic signed [SAMPLE_WIDTH-1:0] req_accel_x,
   input  wire logic signed [SAMPLE_WIDTH-1:0] req_accel_y,
   input  wire logic signed [SAMPLE_WIDTH-1:0] req_accel_z,

   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic                                rsp_flipped,
   output logic                                rsp_changed,
   output logic [ZoneWidth-1:0]                rsp_zone,

   input  wire logic                           psel,
   input  wire logic                           penable,
   input  wire logic                           pwrite,
   input  wire logic [AddrWidth-1:0]           paddr,
   input  wire logic [DataWidth-1:0]           pwdata,
   output logic      [DataWidth-1:0]           prdata,
   output logic                                pready
);

   cfg_type    cfg;
   result_type result;

   logic                           s1_valid_ff;
   logic                           s1_valid_in;
   logic                           s1_read_ok_ff;
   logic signed [SAMPLE_WIDTH-1:0] s1_x_ff;
   logic signed [SAMPLE_WIDTH-1:0] s1_y_ff;
   logic signed [SAMPLE_WIDTH-1:0] s1_z_ff;

   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   result_type rsp_ff;

   logic req_take;
   logic out_free;
   logic advance;

   gfd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   gfd_tilt #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .COUNT_WIDTH  (COUNT_WIDTH)
   ) u_tilt (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .cfg     (cfg),
      .read_ok (s1_read_ok_ff),
      .accel_x (s1_x_ff),
      .accel_y (s1_y_ff),
      .accel_z (s1_z_ff),
      .result  (result)
   );

   assign out_free    = ~rsp_valid_ff | rsp_ready;
   assign advance     = s1_valid_ff & out_free;
   assign req_ready   = ~s1_valid_ff | out_free;
   assign req_take    = req_valid & req_ready;
   assign s1_valid_in = req_take | (s1_valid_ff & ~advance);
   assign rsp_valid_in = advance | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_read_ok_ff <= req_read_ok;
         s1_x_ff       <= req_accel_x;
         s1_y_ff       <= req_accel_y;
         s1_z_ff       <= req_accel_z;
      end
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_flipped = rsp_ff.flipped;
   assign rsp_changed = rsp_ff.changed;
   assign rsp_zone    = rsp_ff.zone;

`ifndef SYNTH
   // a change to flipped only comes from an upside-down reading
   a_flip_from_upside: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.changed && rsp_ff.flipped |-> rsp_ff.zone == ZONE_UPSIDE)
      else $error("flip committed outside upside-down zone");

   // a change back to normal comes from an upright or a flat reading
   a_unflip_zone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.changed && !rsp_ff.flipped |->
         (rsp_ff.zone == ZONE_UPRIGHT || rsp_ff.zone == ZONE_DEAD))
      else $error("revert committed from wrong zone");

   // a failed read reaches the output as a failed zone and never changes state
   a_failed_read: assert property (@(posedge clock) disable iff (reset)
      advance && !s1_read_ok_ff |=> rsp_valid_ff && rsp_ff.zone == ZONE_FAILED
         && !rsp_ff.changed)
      else $error("failed read not reported as such");

   // the input register never drops an item it holds
   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !advance |=> s1_valid_ff)
      else $error("held item lost from input register");
`endif

endmodule

`default_nettype wire

FILE: src/gfd_csr.sv
`timescale 1ns / 1ps
`default_nettype none

module gfd_csr
   import gfd_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 psel,
   input  wire logic                 penable,
   input  wire logic                 pwrite,
   input  wire logic [AddrWidth-1:0] paddr,
   input  wire logic [DataWidth-1:0] pwdata,
   output logic      [DataWidth-1:0] prdata,
   output logic                      pready,
   output cfg_type                   cfg
);

   cfg_type             cfg_ff;
   cfg_type             cfg_in;
   logic                wr_en;
   logic [IdxWidth-1:0] idx;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite & pready;
   assign idx    = paddr[AddrWidth-1:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            REG_UP_AXIS:    cfg_in.up_axis          = pwdata[AxisWidth-1:0];
            REG_UP_NEGATE:  cfg_in.up_negate        = pwdata[0];
            REG_THRESHOLD:  cfg_in.tilt_threshold   = pwdata[ThrWidth-1:0];
            REG_CONFIRM:    cfg_in.confirm_polls    = pwdata[CfgCountWidth-1:0];
            REG_FLAT_LIMIT: cfg_in.flat_polls_limit = pwdata[CfgCountWidth-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.up_axis          <= ResetUpAxis;
         cfg_ff.up_negate        <= ResetUpNegate;
         cfg_ff.tilt_threshold   <= ResetThreshold;
         cfg_ff.confirm_polls    <= ResetConfirm;
         cfg_ff.flat_polls_limit <= ResetFlatLimit;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (idx)
         REG_UP_AXIS:    prdata = DataWidth'(cfg_ff.up_axis);
         REG_UP_NEGATE:  prdata = DataWidth'(cfg_ff.up_negate);
         REG_THRESHOLD:  prdata = DataWidth'(cfg_ff.tilt_threshold);
         REG_CONFIRM:    prdata = DataWidth'(cfg_ff.confirm_polls);
         REG_FLAT_LIMIT: prdata = DataWidth'(cfg_ff.flat_polls_limit);
         default:        prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

FILE: src/gfd_tilt.sv
`timescale 1ns / 1ps
`default_nettype none

module gfd_tilt
   import gfd_pkg::*;
#(
   parameter int SAMPLE_WIDTH = SampleWidthDef,
   parameter int COUNT_WIDTH  = CountWidthDef
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           step,
   input  wire cfg_type                        cfg,
   input  wire logic                           read_ok,
   input  wire logic signed [SAMPLE_WIDTH-1:0] accel_x,
   input  wire logic signed [SAMPLE_WIDTH-1:0] accel_y,
   input  wire logic signed [SAMPLE_WIDTH-1:0] accel_z,
   output result_type                          result
);

   // one spare bit so negating the most negative sample cannot overflow
   localparam int UpWidth  = (SAMPLE_WIDTH + 1 > ThrWidth + 1) ? SAMPLE_WIDTH + 1 : ThrWidth + 1;
   localparam int CmpWidth = (COUNT_WIDTH > CfgCountWidth) ? COUNT_WIDTH : CfgCountWidth;
   localparam logic [COUNT_WIDTH-1:0] CountMax = '1;

   logic                          flip_ff;
   logic                          flip_in;
   logic [COUNT_WIDTH-1:0]        pend_ff;
   logic [COUNT_WIDTH-1:0]        pend_in;
   logic [COUNT_WIDTH-1:0]        flat_ff;
   logic [COUNT_WIDTH-1:0]        flat_in;

   logic signed [SAMPLE_WIDTH-1:0] sel_sample;
   logic signed [UpWidth-1:0]      up_raw;
   logic signed [UpWidth-1:0]      up;
   logic signed [UpWidth-1:0]      thr_pos;
   logic signed [UpWidth-1:0]      thr_neg;
   logic                           above;
   logic                           below;
   logic [COUNT_WIDTH-1:0]         pend_inc;
   logic [COUNT_WIDTH-1:0]         flat_inc;
   logic                           pend_hit;
   logic                           flat_hit;

   always_comb begin
      case (cfg.up_axis)
         AXIS_X:  sel_sample = accel_x;
         AXIS_Y:  sel_sample = accel_y;
         AXIS_Z:  sel_sample = accel_z;
         default: sel_sample = '0;
      endcase
   end

   assign up_raw  = UpWidth'(sel_sample);
   assign up      = cfg.up_negate ? -up_raw : up_raw;
   assign thr_pos = signed'(UpWidth'(cfg.tilt_threshold));
   assign thr_neg = -thr_pos;
   assign above   = up > thr_pos;
   assign below   = up < thr_neg;

   // saturating increments
   assign pend_inc = (pend_ff == CountMax) ? pend_ff : pend_ff + 1'b1;
   assign flat_inc = (flat_ff == CountMax) ? flat_ff : flat_ff + 1'b1;
   assign pend_hit = CmpWidth'(pend_inc) >= CmpWidth'(cfg.confirm_polls);
   assign flat_hit = CmpWidth'(flat_inc) >= CmpWidth'(cfg.flat_polls_limit);

   always_comb begin
      flip_in        = flip_ff;
      pend_in        = pend_ff;
      flat_in        = flat_ff;
      result.changed = 1'b0;
      result.zone    = ZONE_FAILED;
      if (read_ok) begin
         if (above || below) begin
            result.zone = below ? ZONE_UPSIDE : ZONE_UPRIGHT;
            flat_in     = '0;
            if (below == flip_ff) begin
               pend_in = '0;
            end else if (pend_hit) begin
               pend_in        = '0;
               flip_in        = below;
               result.changed = 1'b1;
            end else begin
               pend_in = pend_inc;
            end
         end else begin
            result.zone = ZONE_DEAD;
            pend_in     = '0;
            if (flat_hit) begin
               // long enough flat: fall back to normal orientation
               flat_in        = '0;
               flip_in        = 1'b0;
               result.changed = flip_ff;
            end else begin
               flat_in = flat_inc;
            end
         end
      end
      result.flipped = flip_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flip_ff <= 1'b0;
         pend_ff <= '0;
         flat_ff <= '0;
      end else if (step) begin
         flip_ff <= flip_in;
         pend_ff <= pend_in;
         flat_ff <= flat_in;
      end
   end

endmodule

`default_nettype wire
